>>> rtl/core/tsr_pkg.sv
// tsr_pkg: types, microcode program and step addresses for the totient range sum block.
// No dependencies. Used by totient_range_sum_top.
package tsr_pkg;

   localparam int PC_BITS = 5;

   // datapath operations, one per control word
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD_N,   // m = n, r = n, p = 2
      OP_SQUARE,   // pp = p * p
      OP_DIV_MP,   // start m / p
      OP_DIV_RP,   // start r / p
      OP_DIV_RM,   // start r / m
      OP_TAKE_Q,   // m = quotient
      OP_SUB_Q,    // r = r - quotient
      OP_INC_P,
      OP_ACC,      // sum += r
      OP_INC_N,
      OP_FINISH    // load result word, go idle
   } op_type;

   // jump conditions
   typedef enum logic [3:0] {
      C_NONE,
      C_ALWAYS,
      C_EMPTY,     // n > hi
      C_N_LT2,
      C_PP_GT_M,
      C_REM_NZ,
      C_REM_Z,
      C_DIV_BUSY,
      C_M_LE1,
      C_N_EQ_HI,
      C_OUT_FULL
   } cond_type;

   typedef struct packed {
      op_type               op;
      cond_type             cond;
      logic [PC_BITS-1:0]   target;
   } ucode_type;

   localparam logic [PC_BITS-1:0] A_START  = 5'd0;
   localparam logic [PC_BITS-1:0] A_NEW_N  = 5'd1;
   localparam logic [PC_BITS-1:0] A_SQ     = 5'd2;
   localparam logic [PC_BITS-1:0] A_W1     = 5'd5;
   localparam logic [PC_BITS-1:0] A_STRIP  = 5'd7;
   localparam logic [PC_BITS-1:0] A_W2     = 5'd9;
   localparam logic [PC_BITS-1:0] A_W3     = 5'd12;
   localparam logic [PC_BITS-1:0] A_INC    = 5'd14;
   localparam logic [PC_BITS-1:0] A_TAIL   = 5'd15;
   localparam logic [PC_BITS-1:0] A_W4     = 5'd17;
   localparam logic [PC_BITS-1:0] A_ADD    = 5'd19;
   localparam logic [PC_BITS-1:0] A_NEXT   = 5'd20;
   localparam logic [PC_BITS-1:0] A_FIN    = 5'd22;
   localparam logic [PC_BITS-1:0] A_LAST   = 5'd23;

   // Trial division: strip each factor p of m and scale r by (1 - 1/p),
   // then handle a leftover prime m > 1.
   function automatic ucode_type ucode_rom(input logic [PC_BITS-1:0] pc);
      ucode_type w;
      case (pc)
         5'd0:    w = '{OP_NOP,     C_EMPTY,    A_FIN};
         5'd1:    w = '{OP_LOAD_N,  C_N_LT2,    A_NEXT};
         5'd2:    w = '{OP_SQUARE,  C_NONE,     A_START};
         5'd3:    w = '{OP_NOP,     C_PP_GT_M,  A_TAIL};
         5'd4:    w = '{OP_DIV_MP,  C_NONE,     A_START};
         5'd5:    w = '{OP_NOP,     C_DIV_BUSY, A_W1};
         5'd6:    w = '{OP_NOP,     C_REM_NZ,   A_INC};
         5'd7:    w = '{OP_TAKE_Q,  C_NONE,     A_START};
         5'd8:    w = '{OP_DIV_MP,  C_NONE,     A_START};
         5'd9:    w = '{OP_NOP,     C_DIV_BUSY, A_W2};
         5'd10:   w = '{OP_NOP,     C_REM_Z,    A_STRIP};
         5'd11:   w = '{OP_DIV_RP,  C_NONE,     A_START};
         5'd12:   w = '{OP_NOP,     C_DIV_BUSY, A_W3};
         5'd13:   w = '{OP_SUB_Q,   C_NONE,     A_START};
         5'd14:   w = '{OP_INC_P,   C_ALWAYS,   A_SQ};
         5'd15:   w = '{OP_NOP,     C_M_LE1,    A_ADD};
         5'd16:   w = '{OP_DIV_RM,  C_NONE,     A_START};
         5'd17:   w = '{OP_NOP,     C_DIV_BUSY, A_W4};
         5'd18:   w = '{OP_SUB_Q,   C_NONE,     A_START};
         5'd19:   w = '{OP_ACC,     C_NONE,     A_START};
         5'd20:   w = '{OP_NOP,     C_N_EQ_HI,  A_FIN};
         5'd21:   w = '{OP_INC_N,   C_ALWAYS,   A_NEW_N};
         5'd22:   w = '{OP_NOP,     C_OUT_FULL, A_FIN};
         5'd23:   w = '{OP_FINISH,  C_NONE,     A_START};
         default: w = '{OP_FINISH,  C_NONE,     A_START};
      endcase
      return w;
   endfunction

endpackage

>>> rtl/core/tsr_if.sv
// tsr_if: valid/ready channel interfaces for range requests and sum responses.
// No dependencies.
interface tsr_req_if #(parameter int VALUE_BITS = 16);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] range_low;
   logic [VALUE_BITS-1:0] range_high;

   modport source (output valid, output range_low, output range_high, input ready);
   modport sink   (input valid, input range_low, input range_high, output ready);
endinterface

interface tsr_rsp_if #(parameter int SUM_BITS = 32);
   logic                valid;
   logic                ready;
   logic [SUM_BITS-1:0] totient_sum;

   modport source (output valid, output totient_sum, input ready);
   modport sink   (input valid, input totient_sum, output ready);
endinterface

>>> rtl/core/tsr_div.sv
// tsr_div: restoring divider, one quotient bit per cycle.
// No dependencies. Used by totient_range_sum_top.
module tsr_div #(
   parameter int W = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         busy,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);

   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [W:0]    shifted;
   logic [W:0]    diff;

   assign shifted = {rem_ff, quo_ff[W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/core/totient_range_sum_top.sv
// totient_range_sum_top: sums coprime counts over n in [range_low, range_high].
// Per n >= 2: trial divisors p run while p*p <= m; each factor p is divided out of m, however
// often it occurs, and r is scaled by (1 - 1/p); a leftover prime m > 1 scales r once more.
// n below 2 adds nothing. Finish waits while an earlier word is untaken; an empty range gives a zero word.
// One range at a time: next range accepted the cycle after the word loads. Uses tsr_pkg, tsr_div.
// Reset (synchronous, active high) returns the sequencer to idle with no result pending.
module totient_range_sum_top
   import tsr_pkg::*;
#(
   parameter int VALUE_BITS = 16,
   parameter int SUM_BITS   = 32
) (
   input  logic       clock,
   input  logic       reset,
   tsr_req_if.sink    req_chan,
   tsr_rsp_if.source  rsp_chan
);

   localparam int VB = VALUE_BITS;
   localparam int SB = SUM_BITS;

   logic                run_ff, run_in;
   logic [PC_BITS-1:0]  pc_ff, pc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0]       rsp_data_ff, rsp_data_in;

   logic [VB-1:0]       n_ff, n_in;
   logic [VB-1:0]       hi_ff, hi_in;
   logic [VB-1:0]       m_ff, m_in;
   logic [VB-1:0]       r_ff, r_in;
   logic [VB-1:0]       p_ff, p_in;
   logic [2*VB-1:0]     pp_ff, pp_in;
   logic [SB-1:0]       sum_ff, sum_in;

   ucode_type           uw;
   logic                req_fire;
   logic                jump;
   logic                out_full;

   logic                div_start;
   logic [VB-1:0]       div_a;
   logic [VB-1:0]       div_b;
   logic                div_busy;
   logic [VB-1:0]       div_q;
   logic [VB-1:0]       div_r;

   assign uw       = ucode_rom(pc_ff);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_full = rsp_valid_ff && !rsp_chan.ready;

   assign req_chan.ready      = !run_ff;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.totient_sum = rsp_data_ff;

   tsr_div #(.W(VB)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .busy      (div_busy),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // jump condition
   always_comb begin
      case (uw.cond)
         C_NONE:     jump = 1'b0;
         C_ALWAYS:   jump = 1'b1;
         C_EMPTY:    jump = (n_ff > hi_ff);
         C_N_LT2:    jump = (n_ff < VB'(2));
         C_PP_GT_M:  jump = (pp_ff > {{VB{1'b0}}, m_ff});
         C_REM_NZ:   jump = (div_r != '0);
         C_REM_Z:    jump = (div_r == '0);
         C_DIV_BUSY: jump = div_busy;
         C_M_LE1:    jump = (m_ff < VB'(2));
         C_N_EQ_HI:  jump = (n_ff == hi_ff);
         C_OUT_FULL: jump = out_full;
         default:    jump = 1'b0;
      endcase
   end

   // divider operand select
   always_comb begin
      div_start = run_ff && (uw.op == OP_DIV_MP || uw.op == OP_DIV_RP || uw.op == OP_DIV_RM);
      case (uw.op)
         OP_DIV_MP: begin div_a = m_ff; div_b = p_ff; end
         OP_DIV_RP: begin div_a = r_ff; div_b = p_ff; end
         OP_DIV_RM: begin div_a = r_ff; div_b = m_ff; end
         default:   begin div_a = m_ff; div_b = p_ff; end
      endcase
   end

   // sequencer and datapath next values
   always_comb begin
      run_in       = run_ff;
      pc_in        = pc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      n_in         = n_ff;
      hi_in        = hi_ff;
      m_in         = m_ff;
      r_in         = r_ff;
      p_in         = p_ff;
      pp_in        = pp_ff;
      sum_in       = sum_ff;

      if (req_fire) begin
         run_in = 1'b1;
         pc_in  = A_START;
         n_in   = req_chan.range_low;
         hi_in  = req_chan.range_high;
         sum_in = '0;
      end else if (run_ff) begin
         pc_in = jump ? uw.target : pc_ff + 1'b1;
         case (uw.op)
            OP_LOAD_N: begin
               m_in = n_ff;
               r_in = n_ff;
               p_in = VB'(2);
            end
            OP_SQUARE: pp_in  = p_ff * p_ff;
            OP_TAKE_Q: m_in   = div_q;
            OP_SUB_Q:  r_in   = r_ff - div_q;
            OP_INC_P:  p_in   = p_ff + 1'b1;
            OP_ACC:    sum_in = sum_ff + SB'(r_ff);
            OP_INC_N:  n_in   = n_ff + 1'b1;
            OP_FINISH: begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sum_ff;
               run_in       = 1'b0;
               pc_in        = A_START;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         pc_ff        <= A_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      n_ff        <= n_in;
      hi_ff       <= hi_in;
      m_ff        <= m_in;
      r_ff        <= r_in;
      p_ff        <= p_in;
      pp_ff       <= pp_in;
      sum_ff      <= sum_in;
   end

   // a result word appears only from the finish step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(run_ff && uw.op == OP_FINISH))
      else $error("response raised outside finish step");

   // the divider is never restarted mid-divide
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   // finish never overwrites an untaken word
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (run_ff && uw.op == OP_FINISH) |-> !out_full)
      else $error("result overwritten");

   // the program counter stays inside the program
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (pc_ff <= A_LAST))
      else $error("program counter out of range");

endmodule
